// ===== rtl/core/tlsp_pkg.sv =====
// Package for the traffic light setting panel: command and mode codes,
// payload structs, duration limits and the duration step helpers.
// No dependencies; used by traffic_light_setting_panel.
`timescale 1ns / 1ps
`default_nettype none

package tlsp_pkg;

    // Bus widths (payload packed from bit 0, padded to whole bytes)
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    localparam int DELAY_W   = 6;
    localparam int LIGHTS_W  = 16;

    // Duration limits and reset durations
    localparam logic [DELAY_W-1:0] DELAY_MIN       = 6'd2;
    localparam logic [DELAY_W-1:0] DELAY_MAX       = 6'd60;
    localparam logic [DELAY_W-1:0] RST_GREEN_LEFT  = 6'd6;
    localparam logic [DELAY_W-1:0] RST_GREEN_RIGHT = 6'd12;
    localparam logic [DELAY_W-1:0] RST_RED         = 6'd21;

    // Forced light patterns
    localparam logic [LIGHTS_W-1:0] LIGHTS_EW_GREEN = 16'h0164;
    localparam logic [LIGHTS_W-1:0] LIGHTS_NS_GREEN = 16'h0149;

    typedef enum logic [2:0] {
        CMD_RUN   = 3'd0,
        CMD_HOLD  = 3'd1,
        CMD_PAUSE = 3'd2,
        CMD_INC   = 3'd3,
        CMD_DEC   = 3'd4,
        CMD_DIR   = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'd0,
        MODE_PAGE1    = 3'd1,
        MODE_PAGE2    = 3'd2,
        MODE_PAGE3    = 3'd3,
        MODE_PAGE4    = 3'd4,
        MODE_FORCE_EW = 3'd5,
        MODE_FORCE_NS = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        DISP_COUNTDOWN = 2'd0,
        DISP_DURATION  = 2'd1,
        DISP_DASHES    = 2'd2
    } disp_kind_t;

    // Input transaction, cmd in the low bits
    typedef struct packed {
        logic [LIGHTS_W-1:0] current_lights;
        logic [2:0]          cmd;
    } in_item_t;

    // Result transaction, mode_now in the low bits
    typedef struct packed {
        logic                direction_now;
        logic [DELAY_W-1:0]  display_ns;
        logic [DELAY_W-1:0]  display_ew;
        logic [1:0]          display_kind;
        logic [LIGHTS_W-1:0] light_value;
        logic                light_write;
        logic                run_enable;
        logic [2:0]          mode_now;
    } result_t;

    // Duration after a step of 1 (or 2 when dbl), up or down
    function automatic logic [DELAY_W-1:0] delay_step(
        input logic [DELAY_W-1:0] v,
        input logic               dbl,
        input logic               up
    );
        logic [DELAY_W-1:0] amt;
        amt = dbl ? DELAY_W'(2) : DELAY_W'(1);
        return up ? (v + amt) : (v - amt);
    endfunction

    // True when that step stays within DELAY_MIN..DELAY_MAX
    function automatic logic delay_ok(
        input logic [DELAY_W-1:0] v,
        input logic               dbl,
        input logic               up
    );
        logic [DELAY_W:0] amt;
        logic [DELAY_W:0] wide;
        amt  = dbl ? (DELAY_W+1)'(2) : (DELAY_W+1)'(1);
        wide = {1'b0, v};
        if (up) begin
            return (wide + amt) <= {1'b0, DELAY_MAX};
        end else begin
            return wide >= (amt + {1'b0, DELAY_MIN});
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/traffic_light_setting_panel.sv =====
// Traffic light setting panel: one button event in, one panel status out.
// The input transaction passes the input register, then the result register,
// before the result is valid. Throughput: one transaction per cycle while m_tready
// takes the results, set by the combinational state update between the two registers.
// Reset (aresetn low, synchronous): normal mode, running, east-west favored,
// no saved pattern, durations green left 6, green right 12, red 21.
// Depends on tlsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module traffic_light_setting_panel
    import tlsp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // cmd[2:0], current_lights[18:3], zero pad
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata    // mode_now[2:0], run_enable[3],
                                                 // light_write[4], light_value[20:5],
                                                 // display_kind[22:21], display_ew[28:23],
                                                 // display_ns[34:29], direction_now[35], pad
);

    localparam int IN_W  = $bits(in_item_t);
    localparam int RES_W = $bits(result_t);

    // Pipeline registers
    logic     in_valid_reg;
    in_item_t in_data_reg;
    logic     out_valid_reg;
    result_t  out_data_reg;

    // Panel state
    mode_t               mode_reg, mode_next;
    logic                dir_reg, dir_next;
    logic                run_reg, run_next;
    logic [LIGHTS_W-1:0] saved_reg, saved_next;
    logic [DELAY_W-1:0]  ew_red_reg, ew_red_next;
    logic [DELAY_W-1:0]  ew_gl_reg, ew_gl_next;
    logic [DELAY_W-1:0]  ew_gr_reg, ew_gr_next;
    logic [DELAY_W-1:0]  ns_red_reg, ns_red_next;
    logic [DELAY_W-1:0]  ns_gl_reg, ns_gl_next;
    logic [DELAY_W-1:0]  ns_gr_reg, ns_gr_next;

    logic    advance;
    cmd_t    cmd;
    logic    up;
    result_t result_next;

    // Stepped durations and their range checks
    logic [DELAY_W-1:0] ew_red_s1, ns_red_s1, ew_red_s2, ns_red_s2;
    logic [DELAY_W-1:0] ew_gl_s1, ew_gr_s1, ns_gl_s1, ns_gr_s1;
    logic ew_red_ok1, ns_red_ok1, ew_red_ok2, ns_red_ok2;
    logic ew_gl_ok1, ew_gr_ok1, ns_gl_ok1, ns_gr_ok1;

    // Handshake: the input stage moves on when the result register is empty or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, out_data_reg};

    assign cmd = cmd_t'(in_data_reg.cmd);
    assign up  = (cmd == CMD_INC);

    // Candidate step values
    always_comb begin
        ew_red_s1  = delay_step(ew_red_reg, 1'b0, up);
        ns_red_s1  = delay_step(ns_red_reg, 1'b0, up);
        ew_red_s2  = delay_step(ew_red_reg, 1'b1, up);
        ns_red_s2  = delay_step(ns_red_reg, 1'b1, up);
        ew_gl_s1   = delay_step(ew_gl_reg, 1'b0, up);
        ew_gr_s1   = delay_step(ew_gr_reg, 1'b0, up);
        ns_gl_s1   = delay_step(ns_gl_reg, 1'b0, up);
        ns_gr_s1   = delay_step(ns_gr_reg, 1'b0, up);
        ew_red_ok1 = delay_ok(ew_red_reg, 1'b0, up);
        ns_red_ok1 = delay_ok(ns_red_reg, 1'b0, up);
        ew_red_ok2 = delay_ok(ew_red_reg, 1'b1, up);
        ns_red_ok2 = delay_ok(ns_red_reg, 1'b1, up);
        ew_gl_ok1  = delay_ok(ew_gl_reg, 1'b0, up);
        ew_gr_ok1  = delay_ok(ew_gr_reg, 1'b0, up);
        ns_gl_ok1  = delay_ok(ns_gl_reg, 1'b0, up);
        ns_gr_ok1  = delay_ok(ns_gr_reg, 1'b0, up);
    end

    // Command decode and state update
    always_comb begin
        mode_next   = mode_reg;
        dir_next    = dir_reg;
        run_next    = run_reg;
        saved_next  = saved_reg;
        ew_red_next = ew_red_reg;
        ew_gl_next  = ew_gl_reg;
        ew_gr_next  = ew_gr_reg;
        ns_red_next = ns_red_reg;
        ns_gl_next  = ns_gl_reg;
        ns_gr_next  = ns_gr_reg;
        result_next = '0;

        unique case (cmd)
            CMD_RUN: begin
                mode_next = MODE_NORMAL;
                run_next  = 1'b1;
                if (saved_reg != '0) begin
                    result_next.light_write = 1'b1;
                    result_next.light_value = saved_reg;
                end
            end
            CMD_HOLD: begin
                saved_next = in_data_reg.current_lights;
                run_next   = 1'b0;
                unique case (mode_reg) inside
                    MODE_NORMAL, MODE_FORCE_NS: begin
                        mode_next = MODE_FORCE_EW;
                        result_next.light_write = 1'b1;
                        result_next.light_value = LIGHTS_EW_GREEN;
                    end
                    MODE_FORCE_EW: begin
                        mode_next = MODE_FORCE_NS;
                        result_next.light_write = 1'b1;
                        result_next.light_value = LIGHTS_NS_GREEN;
                    end
                    default: ;
                endcase
            end
            CMD_PAUSE: begin
                // edit pages cycle; forced modes ignore pause
                unique case (mode_reg)
                    MODE_NORMAL: begin mode_next = MODE_PAGE1; run_next = 1'b0; end
                    MODE_PAGE1:  begin mode_next = MODE_PAGE2; run_next = 1'b0; end
                    MODE_PAGE2:  begin mode_next = MODE_PAGE3; run_next = 1'b0; end
                    MODE_PAGE3:  begin mode_next = MODE_PAGE4; run_next = 1'b0; end
                    MODE_PAGE4:  begin mode_next = MODE_PAGE1; run_next = 1'b0; end
                    default: ;
                endcase
            end
            CMD_INC, CMD_DEC: begin
                // a step leaving 2..60 on any touched duration is refused
                unique case (mode_reg)
                    MODE_PAGE1: begin
                        if (ew_red_ok1 && ns_gl_ok1) begin
                            ew_red_next = ew_red_s1;
                            ns_gl_next  = ns_gl_s1;
                        end
                    end
                    MODE_PAGE2: begin
                        if (ew_red_ok1 && ns_gr_ok1) begin
                            ew_red_next = ew_red_s1;
                            ns_gr_next  = ns_gr_s1;
                        end
                    end
                    MODE_PAGE3: begin
                        if (ew_gl_ok1 && ns_red_ok1) begin
                            ew_gl_next  = ew_gl_s1;
                            ns_red_next = ns_red_s1;
                        end
                    end
                    MODE_PAGE4: begin
                        if (ew_gr_ok1 && ns_red_ok1) begin
                            ew_gr_next  = ew_gr_s1;
                            ns_red_next = ns_red_s1;
                        end
                    end
                    default: begin
                        // rebalance toward the favored direction
                        if (!dir_reg) begin
                            if (ns_red_ok2 && ew_gl_ok1 && ew_gr_ok1) begin
                                ns_red_next = ns_red_s2;
                                ew_gl_next  = ew_gl_s1;
                                ew_gr_next  = ew_gr_s1;
                            end
                        end else begin
                            if (ew_red_ok2 && ns_gl_ok1 && ns_gr_ok1) begin
                                ew_red_next = ew_red_s2;
                                ns_gl_next  = ns_gl_s1;
                                ns_gr_next  = ns_gr_s1;
                            end
                        end
                    end
                endcase
            end
            CMD_DIR: dir_next = ~dir_reg;
            default: ;
        endcase

        // Display selection from the updated state
        unique case (mode_next)
            MODE_NORMAL: result_next.display_kind = DISP_COUNTDOWN;
            MODE_PAGE1: begin
                result_next.display_kind = DISP_DURATION;
                result_next.display_ew   = ew_red_next;
                result_next.display_ns   = ns_gl_next;
            end
            MODE_PAGE2: begin
                result_next.display_kind = DISP_DURATION;
                result_next.display_ew   = ew_red_next;
                result_next.display_ns   = ns_gr_next;
            end
            MODE_PAGE3: begin
                result_next.display_kind = DISP_DURATION;
                result_next.display_ew   = ew_gl_next;
                result_next.display_ns   = ns_red_next;
            end
            MODE_PAGE4: begin
                result_next.display_kind = DISP_DURATION;
                result_next.display_ew   = ew_gr_next;
                result_next.display_ns   = ns_red_next;
            end
            default: result_next.display_kind = DISP_DASHES;
        endcase

        result_next.mode_now      = mode_next;
        result_next.run_enable    = run_next;
        result_next.direction_now = dir_next;
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_data_reg <= in_item_t'(s_tdata[IN_W-1:0]);
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_data_reg <= result_next;
        end
    end

    // Panel state, updated once per transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_NORMAL;
            dir_reg    <= 1'b0;
            run_reg    <= 1'b1;
            saved_reg  <= '0;
            ew_red_reg <= RST_RED;
            ew_gl_reg  <= RST_GREEN_LEFT;
            ew_gr_reg  <= RST_GREEN_RIGHT;
            ns_red_reg <= RST_RED;
            ns_gl_reg  <= RST_GREEN_LEFT;
            ns_gr_reg  <= RST_GREEN_RIGHT;
        end else if (advance) begin
            mode_reg   <= mode_next;
            dir_reg    <= dir_next;
            run_reg    <= run_next;
            saved_reg  <= saved_next;
            ew_red_reg <= ew_red_next;
            ew_gl_reg  <= ew_gl_next;
            ew_gr_reg  <= ew_gr_next;
            ns_red_reg <= ns_red_next;
            ns_gl_reg  <= ns_gl_next;
            ns_gr_reg  <= ns_gr_next;
        end
    end

    // Checks
    a_delays_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ew_red_reg >= DELAY_MIN && ew_red_reg <= DELAY_MAX &&
        ns_red_reg >= DELAY_MIN && ns_red_reg <= DELAY_MAX &&
        ew_gl_reg >= DELAY_MIN && ew_gl_reg <= DELAY_MAX &&
        ns_gl_reg >= DELAY_MIN && ns_gl_reg <= DELAY_MAX &&
        ew_gr_reg >= DELAY_MIN && ew_gr_reg <= DELAY_MAX &&
        ns_gr_reg >= DELAY_MIN && ns_gr_reg <= DELAY_MAX)
        else $error("duration left 2..60");

    a_hold_stops_run: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && cmd == CMD_HOLD |=> !run_reg && saved_reg == $past(in_data_reg.current_lights))
        else $error("hold did not stop the sequencer or save the lights");

    a_no_write_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_data_reg.light_write |-> out_data_reg.light_value == '0)
        else $error("light value without write");

    a_kind_matches_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((out_data_reg.display_kind == DISP_DURATION) ==
            (out_data_reg.mode_now == MODE_PAGE1 || out_data_reg.mode_now == MODE_PAGE2 ||
             out_data_reg.mode_now == MODE_PAGE3 || out_data_reg.mode_now == MODE_PAGE4)))
        else $error("display kind does not match mode");

endmodule

`default_nettype wire
